/* hw/rtl/lru_key_cache_tracker_top_macros.svh */
// Assertion helpers used by the checker file
`ifndef LRU_KEY_CACHE_TRACKER_TOP_MACROS_SVH
`define LRU_KEY_CACHE_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define LKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lkc_pkg.sv */
`default_nettype none
package lkc_pkg;

  // Cache geometry
  localparam int CAPACITY   = 64;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths
  localparam int CODE_W     = 21;
  localparam int LIM_W      = 7;
  localparam int OUT_SLOT_W = 6;
  localparam int CMP_W      = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;

  // Stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 1 + OUT_SLOT_W + 1 + CODE_W;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic compare;
    logic select;
    logic update;
  } lkc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_blocked;
  } lkc_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/lkc_ctrl.sv */
`default_nettype none
module lkc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  lkc_pkg::lkc_sts_t sts,
  output lkc_pkg::lkc_cmd_t cmd
);
  import lkc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Commands decoded from the current state
  always_comb begin
    cmd         = '0;
    cmd.capture = in_tvalid && in_tready;
    cmd.compare = (state_r == ST_CMP);
    cmd.select  = (state_r == ST_SEL);
    cmd.update  = (state_r == ST_UPD) && !sts.out_blocked;
  end

  // Next state: compare, select, then update once the output register is free
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CMP;
      end
      ST_CMP:  state_nxt = ST_SEL;
      ST_SEL:  state_nxt = ST_UPD;
      ST_UPD: begin
        if (!sts.out_blocked) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lkc_datapath.sv */
`default_nettype none
module lkc_datapath (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [lkc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire                             cfg_we,
  input  wire  [lkc_pkg::LIM_W-1:0]       cfg_wdata,
  input  lkc_pkg::lkc_cmd_t               cmd,
  output lkc_pkg::lkc_sts_t               sts,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [lkc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lkc_pkg::*;

  // Entry cells
  logic [CODE_W-1:0] key_r   [CAPACITY];
  logic [SLOT_W-1:0] rank_r  [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic [CNT_W-1:0]  count_r;
  logic [LIM_W-1:0]  limit_r;

  // Per-transaction working registers
  logic [CODE_W-1:0]   code_r;
  logic [CAPACITY-1:0] match_r;
  logic                hit_r;
  logic [CAPACITY-1:0] sel_oh_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   hit_rank_r;

  // Output register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic                out_evicted_r;
  logic [CODE_W-1:0]   out_code_r;

  // Selection logic (select cycle)
  logic                hit_c;
  logic [CAPACITY-1:0] free_vec;
  logic [CAPACITY-1:0] free_oh;
  logic [SLOT_W-1:0]   hit_bin;
  logic [SLOT_W-1:0]   free_bin;
  logic [SLOT_W-1:0]   hit_rank_c;

  // Update logic (update cycle)
  logic [CMP_W-1:0]    lim_ext;
  logic [CMP_W-1:0]    eff_lim;
  logic [CMP_W-1:0]    cnt_inc;
  logic                evict_c;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CAPACITY-1:0] victim_oh;
  logic [CODE_W-1:0]   victim_code;
  logic [SLOT_W+OUT_SLOT_W-1:0] slot_wide;

  assign sts.out_blocked = out_valid_r && !out_tready;

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIM_W'(64);
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Input capture and parallel key compare
  always_ff @(posedge clk) begin
    if (cmd.capture) code_r <= in_tdata[CODE_W-1:0];
    if (cmd.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= valid_r[i] && (key_r[i] == code_r);
      end
    end
  end

  // Hit slot, its rank and the lowest free slot
  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + CAPACITY'(1));

  always_comb begin
    hit_c      = |match_r;
    hit_bin    = '0;
    free_bin   = '0;
    hit_rank_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_r[i]) begin
        hit_bin    = hit_bin | SLOT_W'(i);
        hit_rank_c = hit_rank_c | rank_r[i];
      end
      if (free_oh[i]) free_bin = free_bin | SLOT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      hit_r      <= hit_c;
      sel_oh_r   <= hit_c ? match_r : free_oh;
      slot_r     <= hit_c ? hit_bin : free_bin;
      hit_rank_r <= hit_rank_c;
    end
  end

  // Eviction decision: the oldest entry holds rank count-1 before insertion
  assign lim_ext = CMP_W'(limit_r);
  always_comb begin
    if (lim_ext < CMP_W'(2)) begin
      eff_lim = CMP_W'(2);
    end else if (lim_ext > CMP_W'(CAPACITY)) begin
      eff_lim = CMP_W'(CAPACITY);
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign cnt_inc = CMP_W'(count_r) + CMP_W'(1);
  assign evict_c = !hit_r && (cnt_inc >= eff_lim);
  assign cnt_m1  = count_r - CNT_W'(1);

  always_comb begin
    victim_code = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      victim_oh[i] = evict_c && valid_r[i] && (rank_r[i] == cnt_m1[SLOT_W-1:0]);
      if (victim_oh[i]) victim_code = victim_code | key_r[i];
    end
  end

  // Cell state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (hit_r) begin
          if (sel_oh_r[i]) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
            rank_r[i] <= rank_r[i] + SLOT_W'(1);
          end
        end else if (sel_oh_r[i]) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (victim_oh[i]) begin
          valid_r[i] <= 1'b0;
          rank_r[i]  <= '0;
        end else if (valid_r[i]) begin
          rank_r[i] <= rank_r[i] + SLOT_W'(1);
        end
      end
      if (!hit_r && !evict_c) count_r <= count_r + CNT_W'(1);
    end
  end

  // Key store: payload only
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.update && !hit_r && sel_oh_r[i]) key_r[i] <= code_r;
    end
  end

  // Result register
  assign slot_wide = {{OUT_SLOT_W{1'b0}}, slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r     <= hit_r;
      out_slot_r    <= slot_wide[OUT_SLOT_W-1:0];
      out_evicted_r <= evict_c;
      out_code_r    <= victim_code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}},
                       out_code_r, out_evicted_r, out_slot_r, out_hit_r};

endmodule
`default_nettype wire

/* hw/rtl/lru_key_cache_tracker_top.sv */
// LRU key cache tracker
//
// Input stream in_*: one character code per transaction in in_tdata.
// Output stream out_*: one result per input transaction, in order.
// Configuration: cfg_we writes cfg_wdata into the eviction limit register;
// write it only while no transaction is in flight.
//
// Timing: an accepted code is compared against all 64 entries in parallel,
// the hit, free slot and rank are selected in the next cycle, and the recency
// ranks, key store and result register are then updated, after which the
// result shows on out_tvalid. The compare/select/update sequencer handles
// one code at a time and takes no new code until its update is done.
// If a result is still waiting in the output register, the update step holds
// until out_tready takes it, so a stalled receiver stalls the input.
//
// Reset (rst_n low, synchronous) empties the cache, clears the entry count,
// drops out_tvalid and sets the limit to 64. No clearing pass is needed.
`default_nettype none
module lru_key_cache_tracker_top (
  input  wire                             clk,
  input  wire                             rst_n,
  // in_tdata: [20:0] char_code
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [lkc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [0] hit, [6:1] slot_index, [7] evicted, [28:8] evicted_code
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [lkc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire                             cfg_we,
  input  wire  [lkc_pkg::LIM_W-1:0]       cfg_wdata
);
  import lkc_pkg::*;

  lkc_cmd_t cmd;
  lkc_sts_t sts;

  // Sequencer
  lkc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry cells and result register
  lkc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* hw/rtl/lkc_checker.sv */
`default_nettype none
`include "lru_key_cache_tracker_top_macros.svh"
module lkc_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [lkc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import lkc_pkg::*;

  // A result waiting for the receiver stays offered
  `LKC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // One code at a time: the input closes after an accepted transaction
  `LKC_ASSERT_NEXT(a_in_busy, in_tvalid && in_tready, !in_tready, "input open during lookup")

  // A hit never evicts
  `LKC_ASSERT_NOW(a_hit_no_evict, out_tvalid && out_tdata[0], !out_tdata[7], "eviction on a hit")

  // Evicted code is zero unless an eviction is reported
  `LKC_ASSERT_NOW(a_code_zero, out_tvalid && !out_tdata[7], out_tdata[28:8] == '0, "stray evicted code")

endmodule

bind lru_key_cache_tracker_top lkc_checker u_lkc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
